### hdl/b64enc_pkg.sv
// Shared types, constants and the character lookup for the base64 stream encoder.
package b64enc_pkg;

    localparam int unsigned CharWidth  = 8;
    localparam int unsigned SlotCount  = 4;
    localparam int unsigned QueueDepth = 2;

    localparam logic [CharWidth-1:0] PadChar = 8'h3D;

    typedef enum logic [2:0] {
        POS_FIRST  = 3'b001,
        POS_SECOND = 3'b010,
        POS_THIRD  = 3'b100
    } group_pos_t;

    // One input byte's worth of work: up to four characters for the back end.
    typedef struct packed {
        logic [SlotCount-1:0][CharWidth-1:0] chars;
        logic [1:0]                          last_idx;
        logic                                is_final;
    } char_batch_t;

    // Map a 6-bit value onto the standard alphabet.
    function automatic logic [CharWidth-1:0] enc_char(input logic [5:0] v);
        logic [CharWidth-1:0] c;
        begin
            if (v < 6'd26)
            begin
                c = 8'h41 + {2'b00, v};
            end
            else if (v < 6'd52)
            begin
                c = 8'h61 + {2'b00, v} - 8'd26;
            end
            else if (v < 6'd62)
            begin
                c = 8'h30 + {2'b00, v} - 8'd52;
            end
            else if (v == 6'd62)
            begin
                c = 8'h2B;
            end
            else
            begin
                c = 8'h2F;
            end
            return c;
        end
    endfunction

endpackage

### hdl/b64enc_front.sv
// Front end: tracks group position and leftover bits, turns each byte into a character batch.
module b64enc_front
    import b64enc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic [7:0]  data_byte,
    input  logic        is_final,
    output char_batch_t batch
);

    group_pos_t pos_reg, pos_next;
    logic [3:0] left_reg, left_next;

    always_comb
    begin
        batch.chars    = {SlotCount{PadChar}};
        batch.last_idx = 2'd0;
        batch.is_final = is_final;
        pos_next       = pos_reg;
        left_next      = left_reg;
        case (pos_reg)
            POS_SECOND:
            begin
                batch.chars[0] = enc_char({left_reg[1:0], data_byte[7:4]});
                batch.chars[1] = enc_char({data_byte[3:0], 2'b00});
                batch.last_idx = is_final ? 2'd2 : 2'd0;
                pos_next       = POS_THIRD;
                left_next      = data_byte[3:0];
            end
            POS_THIRD:
            begin
                batch.chars[0] = enc_char({left_reg, data_byte[7:6]});
                batch.chars[1] = enc_char(data_byte[5:0]);
                batch.last_idx = 2'd1;
                pos_next       = POS_FIRST;
                left_next      = 4'd0;
            end
            default:
            begin
                batch.chars[0] = enc_char(data_byte[7:2]);
                batch.chars[1] = enc_char({data_byte[1:0], 4'b0000});
                batch.last_idx = is_final ? 2'd3 : 2'd0;
                pos_next       = POS_SECOND;
                left_next      = {2'b00, data_byte[1:0]};
            end
        endcase
        if (is_final)
        begin
            pos_next  = POS_FIRST;
            left_next = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= POS_FIRST;
            left_reg <= 4'd0;
        end
        else if (take)
        begin
            pos_reg  <= pos_next;
            left_reg <= left_next;
        end
    end

endmodule

### hdl/b64enc_queue.sv
// Two-entry queue of character batches between front and back ends.
module b64enc_queue
    import b64enc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  char_batch_t push_data,
    input  logic        pop,
    output char_batch_t head,
    output logic        not_empty,
    output logic        full
);

    char_batch_t slot_reg [QueueDepth];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg;

    assign head      = slot_reg[rd_ptr_reg];
    assign not_empty = (count_reg != 2'd0);
    assign full      = (count_reg == 2'(QueueDepth));

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("queue pushed while full");
    assert property (@(posedge clk) disable iff (!rst_n) !not_empty |-> !pop)
        else $error("queue popped while empty");
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= 2'(QueueDepth))
        else $error("queue count out of range");

endmodule

### hdl/b64enc_back.sv
// Back end: walks each batch one character per cycle into the output register, unless the output stalls.
module b64enc_back
    import b64enc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  char_batch_t head,
    input  logic        head_valid,
    output logic        pop,
    output logic [7:0]  out_char,
    output logic        last_char,
    output logic        out_valid,
    input  logic        out_stall
);

    char_batch_t cur_reg;
    logic        cur_valid_reg;
    logic [1:0]  idx_reg;
    logic [7:0]  char_reg;
    logic        last_reg;
    logic        valid_reg;
    logic        emit;
    logic        done;

    assign emit = cur_valid_reg && (!valid_reg || !out_stall);
    assign done = emit && (idx_reg == cur_reg.last_idx);
    assign pop  = head_valid && (!cur_valid_reg || done);

    assign out_char  = char_reg;
    assign last_char = last_reg;
    assign out_valid = valid_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
        if (emit)
        begin
            char_reg <= cur_reg.chars[idx_reg];
            last_reg <= cur_reg.is_final && (idx_reg == cur_reg.last_idx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= 2'd0;
            end
            else if (done)
            begin
                cur_valid_reg <= 1'b0;
                idx_reg       <= 2'd0;
            end
            else if (emit)
            begin
                idx_reg <= idx_reg + 2'd1;
            end
            if (emit)
            begin
                valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (idx_reg <= cur_reg.last_idx))
        else $error("character index past end of batch");
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !done) |=> (cur_valid_reg && idx_reg == $past(idx_reg) + 2'd1))
        else $error("batch dropped before its last character");
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (!cur_valid_reg || done))
        else $error("new batch loaded over an unfinished one");

endmodule

### hdl/base64_stream_encoder.sv
// Top level of the base64 stream encoder.
// Streaming standard base64 encoder: each transaction on the input carries one raw byte and a
// final flag; the output gives one ASCII character per transaction (A-Z, a-z, 0-9, '+', '/',
// or '=' padding), with last_char set on the closing character of a message. A byte opening a
// three-byte group yields one character, the second one, the third two; a final byte also
// flushes the pending bits and pads to a full four-character group. Internally a front end
// tracks the group position and turns each accepted byte into a batch of one to four
// characters, a two-entry queue holds batches, and a back end plays them out at one character
// per cycle, unless out_stall holds it, through a registered output. A byte is accepted in
// any cycle the queue has room, so short bursts go in back to back; sustained throughput is
// set by the single output port: one character per cycle when not stalled, i.e. four
// characters per three bytes, up to four for a final byte. A byte's characters go through
// a queue slot, the batch and output registers. No memory needs clearing after reset.
module base64_stream_encoder
    import b64enc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       is_final,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       last_char
);

    char_batch_t new_batch;
    char_batch_t head_batch;
    logic        take;
    logic        q_full;
    logic        q_not_empty;
    logic        q_pop;

    // Hold the input off only while the batch queue is full.
    assign in_stall = q_full;
    assign take     = in_valid && !q_full;

    b64enc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (data_byte),
        .is_final  (is_final),
        .batch     (new_batch)
    );

    b64enc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .push_data (new_batch),
        .pop       (q_pop),
        .head      (head_batch),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    b64enc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_batch),
        .head_valid (q_not_empty),
        .pop        (q_pop),
        .out_char   (out_char),
        .last_char  (last_char),
        .out_valid  (out_valid),
        .out_stall  (out_stall)
    );

endmodule

### test/b64enc_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the base64 stream encoder: predicts characters and checks the output.
module b64enc_checker
    import b64enc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [7:0]        data_byte,
    input  logic              is_final,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [7:0]        out_char,
    input  logic              last_char,
    output int unsigned       fail_count,
    output int unsigned       pending_count
);

    localparam logic [8*64-1:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [CharWidth-1:0] ch;
        logic                 last;
    } b64_char_t;

    b64_char_t  expected_chars[$];
    b64_char_t  oldest;
    group_pos_t group_pos;
    logic [3:0] carry_bits;

    function automatic logic [CharWidth-1:0] sextet_to_ascii(input logic [5:0] v);
        return B64_ALPHABET[8*(63-v) +: 8];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic push_char(input logic [CharWidth-1:0] ch, input logic last);
        b64_char_t c;
        c.ch   = ch;
        c.last = last;
        expected_chars.push_back(c);
    endtask

    // Advance the group state by one byte and queue the characters it produces.
    task automatic encode_byte(input logic [7:0] b, input logic fin);
        case (group_pos)
            POS_SECOND:
            begin
                push_char(sextet_to_ascii({carry_bits[1:0], b[7:4]}), 1'b0);
                if (fin)
                begin
                    push_char(sextet_to_ascii({b[3:0], 2'b00}), 1'b0);
                    push_char(PadChar, 1'b1);
                end
                carry_bits = b[3:0];
                group_pos  = POS_THIRD;
            end
            POS_THIRD:
            begin
                push_char(sextet_to_ascii({carry_bits, b[7:6]}), 1'b0);
                push_char(sextet_to_ascii(b[5:0]), fin);
                carry_bits = 4'd0;
                group_pos  = POS_FIRST;
            end
            default:
            begin
                push_char(sextet_to_ascii(b[7:2]), 1'b0);
                if (fin)
                begin
                    push_char(sextet_to_ascii({b[1:0], 4'b0000}), 1'b0);
                    push_char(PadChar, 1'b0);
                    push_char(PadChar, 1'b1);
                end
                carry_bits = {2'b00, b[1:0]};
                group_pos  = POS_SECOND;
            end
        endcase
        if (fin)
        begin
            group_pos  = POS_FIRST;
            carry_bits = 4'd0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_chars.delete();
            group_pos     = POS_FIRST;
            carry_bits    = 4'd0;
            pending_count = 0;
            fail_count    = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                encode_byte(data_byte, is_final);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_chars.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected char 0x%02h last=%0b",
                                              out_char, last_char));
                end
                else
                begin
                    oldest = expected_chars.pop_front();
                    if (out_char !== oldest.ch)
                    begin
                        report_mismatch($sformatf("out_char 0x%02h, want 0x%02h",
                                                  out_char, oldest.ch));
                    end
                    if (last_char !== oldest.last)
                    begin
                        report_mismatch($sformatf("last_char %0b, want %0b (char 0x%02h)",
                                                  last_char, oldest.last, oldest.ch));
                    end
                end
            end
            pending_count = expected_chars.size();
        end
    end

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// Testbench top for the base64 stream encoder: clock, reset, stimulus, back-pressure and verdict.
module tb;

    // Longest deliberate output hold-off, in cycles.
    localparam int unsigned HOLD_CYCLES    = 200;
    // Cycles with no transaction on either channel before the run is declared hung.
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    // Settle time after the last expected character.
    localparam int unsigned DRAIN_CYCLES   = 20;
    localparam int unsigned TARGET_BYTES   = 500;
    localparam int unsigned DIRECTED_COUNT = 24;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] data_byte = 8'h00;
    logic       is_final  = 1'b0;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [7:0] out_char;
    logic       last_char;

    int unsigned fail_count;
    int unsigned pending_count;

    // Knobs set by the stimulus: quiet flags for sender and receiver, and the receiver's hold request.
    logic sender_quiet = 1'b0;
    logic recv_quiet   = 1'b0;
    logic hold_req     = 1'b0;

    int unsigned idle_cycles = 0;
    int unsigned bytes_sent  = 0;

    // Directed messages, back to back:
    //   one byte of zeros (double pad), two bytes of ones (single pad),
    //   three bytes of ones (all '/'), a group that encodes to all '+',
    //   then lengths four, five and six so a group boundary is crossed
    //   before each kind of final flush.
    logic [7:0] directed_bytes [0:DIRECTED_COUNT-1] = '{
        8'h00,
        8'hFF, 8'hFF,
        8'hFF, 8'hFF, 8'hFF,
        8'hFB, 8'hEF, 8'hBE,
        8'h4D, 8'h61, 8'h6E, 8'h00,
        8'h12, 8'h34, 8'h56, 8'h78, 8'h9A,
        8'h01, 8'h23, 8'h45, 8'h67, 8'h89, 8'hAB
    };
    // Bit i set marks directed byte i as the end of its message.
    localparam logic [DIRECTED_COUNT-1:0] DIRECTED_FINAL = 24'h821125;

    always #10 clk = ~clk;

    base64_stream_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .is_final  (is_final),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .last_char (last_char)
    );

    b64enc_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .is_final      (is_final),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_char      (out_char),
        .last_char     (last_char),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Offer one byte and hold it until the transaction completes. Random idle
    // cycles go in front, so gaps land at every group position. The caller
    // returns at the edge that accepted the byte, with valid still high.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while (!sender_quiet && $urandom_range(99) < 23)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        is_final  <= fin;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    // Send one well-formed message with random content, biased toward the
    // all-zero and all-one bytes that hit the ends of the alphabet.
    task automatic send_message(input int unsigned len);
        logic [7:0] b;
        for (int unsigned i = 0; i < len; i++)
        begin
            case ($urandom_range(9))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: b = 8'($urandom_range(255));
            endcase
            send_byte(b, i == len - 1);
        end
    endtask

    // Drop valid and wait until every queued character has drained.
    task automatic pause_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Receiver: random stalls, except during a quiet stretch. A hold request
    // stalls the output solidly for HOLD_CYCLES while the sender keeps going,
    // which backs the block up until it stalls its input.
    initial
    begin
        bit hold_served;
        hold_served = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_served)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_served = 1'b1;
            end
            else
            begin
                out_stall <= !recv_quiet && ($urandom_range(99) < 23);
            end
        end
    end

    // Watchdog: count cycles with no transaction on either channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        int unsigned msg_num;
        int unsigned msg_len;

        // Hold reset, then release it on a rising edge.
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: extremes of the byte, every final position, and
        // leftover bits carried across a group boundary.
        for (int unsigned i = 0; i < DIRECTED_COUNT; i++)
        begin
            send_byte(directed_bytes[i], DIRECTED_FINAL[i]);
        end
        pause_until_drained();

        // Random part: well-formed messages, mostly short so every flush
        // shape comes up often, now and then a long one.
        msg_num = 0;
        while (bytes_sent < TARGET_BYTES)
        begin
            // Quiet stretch on both sides: full-rate traffic with no gaps.
            sender_quiet = (msg_num >= 8 && msg_num < 20);
            recv_quiet   = sender_quiet;

            // Long output hold-off while the sender keeps offering bytes.
            if (msg_num == 30)
            begin
                hold_req = 1'b1;
            end

            // Sender pauses until nothing is left in flight.
            if (msg_num == 50 || msg_num == 75)
            begin
                pause_until_drained();
            end

            if ($urandom_range(9) == 0)
            begin
                msg_len = $urandom_range(40, 13);
            end
            else
            begin
                msg_len = $urandom_range(12, 1);
            end
            send_message(msg_len);
            msg_num++;
        end
        sender_quiet = 1'b0;
        recv_quiet   = 1'b0;

        // Wait for the tail to drain, then give the block time to show any
        // stray character before the verdict.
        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/b64enc_pkg.sv
hdl/b64enc_front.sv
hdl/b64enc_queue.sv
hdl/b64enc_back.sv
hdl/base64_stream_encoder.sv
test/b64enc_checker.sv
test/tb.sv
